// ===== rtl/core/owner_record_table_macros.svh =====
// ----------------------------------------------------------------------------
// Owner record table assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in rst.
// ----------------------------------------------------------------------------
`ifndef OWNER_RECORD_TABLE_MACROS_SVH
`define OWNER_RECORD_TABLE_MACROS_SVH

// same-cycle implication
`define ORT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ORT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ort_pkg.sv =====
// ----------------------------------------------------------------------------
// Owner record table package
// Sizes, operation and status codes, record and sequencer types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ort_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;
  localparam int SLOT_W      = 8;
  localparam int DATA_W      = 32;
  localparam int IN_W        = 104;
  localparam int OUT_W       = 80;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] thread_id;
    logic [DATA_W-1:0] process_id;
    logic [DATA_W-1:0] key;
  } rec_t;

  typedef struct packed {
    logic [DATA_W-1:0] found_thread;
    logic [DATA_W-1:0] found_process;
    logic [SLOT_W-1:0] slot;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESP
  } state_t;

endpackage

// ===== rtl/core/ort_store.sv =====
// ----------------------------------------------------------------------------
// Owner record store
// Record memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ort_store
  import ort_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  rec_t             wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output rec_t             rd_data
);

  rec_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/owner_record_table.sv =====
// ----------------------------------------------------------------------------
// Owner record table
// Packed table of key / owner records with lookup, append and swap remove.
// ----------------------------------------------------------------------------
// Request words enter on s_axis; one result word leaves on m_axis per request.
// The block takes one request at a time: s_axis_tready is high only while
// idle, and stays low until the result word has been taken.
// Insert answers in the cycle after acceptance (full table: status full).
// Lookup walks the records in use through the single read port of the record
// memory, one entry per cycle, and answers on the first hit or after the
// last entry in use misses.
// Remove scans the same way, then, when the hit is not the last entry, reads
// the last record and writes it into the hole.
// The result is held on m_axis until m_axis_tready; no new request is taken
// while it waits. Reset empties the table (count of records to zero); the
// memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module owner_record_table
  import ort_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[1:0], key[33:2], owner_process[65:34], owner_thread[97:66]
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[1:0], slot[9:2], found_process[41:10], found_thread[73:42]
  output logic [OUT_W-1:0] m_axis_tdata
);

  state_t            state;
  state_t            state_next;
  logic [OP_W-1:0]   op;
  logic [DATA_W-1:0] key;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  addr;
  logic [IDX_W-1:0]  cmp_idx;
  logic [IDX_W-1:0]  hit_idx;
  logic              pend;
  result_t           res;

  logic              s_accept;
  logic [OP_W-1:0]   in_op;
  rec_t              in_rec;
  logic              full;
  logic [CNT_W-1:0]  last;
  logic              hit;
  logic              miss_end;
  logic              hit_is_last;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  rec_t              wr_data;
  logic [IDX_W-1:0]  rd_addr;
  rec_t              rd_data;

  assign s_accept          = s_axis_tvalid && s_axis_tready;
  assign in_op             = s_axis_tdata[1:0];
  assign in_rec.key        = s_axis_tdata[33:2];
  assign in_rec.process_id = s_axis_tdata[65:34];
  assign in_rec.thread_id  = s_axis_tdata[97:66];

  assign full        = (used == CNT_W'(TABLE_DEPTH));
  assign last        = used - CNT_W'(1);
  assign hit         = (state == S_SCAN) && pend && (rd_data.key == key);
  assign hit_is_last = ({1'b0, cmp_idx} == last);
  assign miss_end    = (state == S_SCAN) && pend && !hit && hit_is_last;

  assign m_axis_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, res};

  ort_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          if ((in_op == OP_LOOKUP || in_op == OP_REMOVE) && used != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op == OP_REMOVE && !hit_is_last) begin
            state_next = S_MOVE_RD;
          end else begin
            state_next = S_RESP;
          end
        end else if (miss_end) begin
          state_next = S_RESP;
        end
      end
      S_MOVE_RD: state_next = S_MOVE_WR;
      S_MOVE_WR: state_next = S_RESP;
      S_RESP: begin
        if (m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = used[IDX_W-1:0];
    wr_data       = in_rec;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en         = s_axis_tvalid && in_op == OP_INSERT && !full;
      end
      S_SCAN:    rd_addr = addr[IDX_W-1:0];
      S_MOVE_RD: rd_addr = last[IDX_W-1:0];
      S_MOVE_WR: begin
        wr_en   = 1'b1;
        wr_addr = hit_idx;
        wr_data = rd_data;
      end
      S_RESP:    m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            op   <= in_op;
            key  <= in_rec.key;
            addr <= '0;
            pend <= 1'b0;
            if (in_op == OP_INSERT && !full) begin
              res  <= '{found_thread: in_rec.thread_id,
                        found_process: in_rec.process_id,
                        slot: SLOT_W'(used[IDX_W-1:0]), status: STAT_OK};
              used <= used + CNT_W'(1);
            end else if (in_op == OP_INSERT) begin
              res  <= '{found_thread: '0, found_process: '0, slot: '0,
                        status: STAT_FULL};
            end else begin
              res  <= '{found_thread: '0, found_process: '0, slot: '0,
                        status: STAT_NOT_FOUND};
            end
          end
        end
        S_SCAN: begin
          addr    <= addr + CNT_W'(1);
          pend    <= (addr < used);
          cmp_idx <= addr[IDX_W-1:0];
          if (hit) begin
            hit_idx <= cmp_idx;
            res     <= '{found_thread: rd_data.thread_id,
                         found_process: rd_data.process_id,
                         slot: SLOT_W'(cmp_idx), status: STAT_OK};
            if (op == OP_REMOVE && hit_is_last) begin
              used <= last;
            end
          end
        end
        S_MOVE_WR: used <= last;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ort_checker.sv =====
// ----------------------------------------------------------------------------
// Owner record table checker
// Port-level checks on the request / result handshake and the status code, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "owner_record_table_macros.svh"

module ort_checker
  import ort_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic s_fire;
  logic m_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  `ORT_ASSERT_NEXT(a_result_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word dropped or changed while stalled")
  `ORT_ASSERT_NOW(a_one_at_a_time, 1'b1, !(s_axis_tready && m_axis_tvalid), "request taken while a result is pending")
  `ORT_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_axis_tready, "ready after accepting a request")
  `ORT_ASSERT_NEXT(a_idle_after_result, m_fire, s_axis_tready && !m_axis_tvalid, "not idle after result word taken")
  `ORT_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "undefined status code")

endmodule

bind owner_record_table ort_checker u_ort_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_owner_record_table.sv =====
// ----------------------------------------------------------------------------
// Owner record table testbench
// Streams lookup, insert and remove requests into the table and checks each
// result word against a shadow copy of the records kept in the testbench.
// Directed requests cover empty, duplicate, swap-remove and unused-code cases.
// Random traffic then fills the table to full, drains it and mixes the
// operations, while both stream sides stall in two idle profiles and run freely in a third.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_owner_record_table;
  import ort_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int ITEMS_PER_PHASE = 267;
  localparam int REPORT_CAP      = 40;

  typedef struct packed {
    logic [DATA_W-1:0] tid;
    logic [DATA_W-1:0] pid;
    logic [DATA_W-1:0] tag;
    logic [OP_W-1:0]   op;
  } request_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} walk_t;

  class owner_table_shadow;
    logic [DATA_W-1:0] tags [TABLE_DEPTH];
    logic [DATA_W-1:0] pids [TABLE_DEPTH];
    logic [DATA_W-1:0] tids [TABLE_DEPTH];
    int unsigned used = 0;
    int unsigned failures = 0;
    result_t pending_answers [$];

    function int find_tag(logic [DATA_W-1:0] t);
      for (int i = 0; i < int'(used); i++)
        if (tags[i] == t) return i;
      return -1;
    endfunction

    function void note_request(request_t r);
      result_t ans;
      int hit;
      int last;
      ans = '0;
      ans.status = STAT_NOT_FOUND;
      case (r.op)
        OP_LOOKUP: begin
          hit = find_tag(r.tag);
          if (hit >= 0) begin
            ans.status        = STAT_OK;
            ans.slot          = SLOT_W'(hit);
            ans.found_process = pids[hit];
            ans.found_thread  = tids[hit];
          end
        end
        OP_INSERT: begin
          if (used >= TABLE_DEPTH) begin
            ans.status = STAT_FULL;
          end else begin
            tags[used]        = r.tag;
            pids[used]        = r.pid;
            tids[used]        = r.tid;
            ans.status        = STAT_OK;
            ans.slot          = SLOT_W'(used);
            ans.found_process = r.pid;
            ans.found_thread  = r.tid;
            used++;
          end
        end
        OP_REMOVE: begin
          hit = find_tag(r.tag);
          if (hit >= 0) begin
            ans.status        = STAT_OK;
            ans.slot          = SLOT_W'(hit);
            ans.found_process = pids[hit];
            ans.found_thread  = tids[hit];
            last = int'(used) - 1;
            // move the last record into the hole
            tags[hit] = tags[last];
            pids[hit] = pids[last];
            tids[hit] = tids[last];
            used = last;
          end
        end
        default: ;
      endcase
      pending_answers.push_back(ans);
    endfunction

    function void flag(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        if (failures < REPORT_CAP)
          $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_answer(result_t got);
      result_t want;
      if (pending_answers.size() == 0) begin
        if (failures < REPORT_CAP)
          $display("%0t ns: unexpected result word, expected none, actual %h", $time, got);
        failures++;
        return;
      end
      want = pending_answers.pop_front();
      flag("status", DATA_W'(want.status), DATA_W'(got.status));
      flag("slot", DATA_W'(want.slot), DATA_W'(got.slot));
      flag("found_process", want.found_process, got.found_process);
      flag("found_thread", want.found_thread, got.found_thread);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  owner_table_shadow shadow = new();
  int src_idle = 12;
  int dst_idle = 49;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  owner_record_table dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic request_t make_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] tag,
                                            logic [DATA_W-1:0] pid, logic [DATA_W-1:0] tid);
    request_t r;
    r.op  = op;
    r.tag = tag;
    r.pid = pid;
    r.tid = tid;
    return r;
  endfunction

  function automatic request_t pick_request(walk_t mode);
    request_t r;
    int roll;
    r = make_request(OP_LOOKUP, $urandom, $urandom, $urandom);
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL:
        r.op = (roll < 85) ? OP_INSERT : (roll < 93) ? OP_LOOKUP :
               (roll < 97) ? OP_REMOVE : OP_UNUSED;
      MODE_DRAIN:
        r.op = (roll < 78) ? OP_REMOVE : (roll < 94) ? OP_LOOKUP :
               (roll < 97) ? OP_INSERT : OP_UNUSED;
      default:
        r.op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_LOOKUP :
               (roll < 95) ? OP_REMOVE : OP_UNUSED;
    endcase
    if ((r.op == OP_LOOKUP || r.op == OP_REMOVE) && shadow.used > 0 &&
        $urandom_range(99) < 85)
      r.tag = shadow.tags[$urandom_range(shadow.used - 1)];
    else if ($urandom_range(99) < 25)
      r.tag = DATA_W'($urandom_range(7));
    return r;
  endfunction

  // leaves tvalid high after the handshake; the next call decides whether to drop it
  task automatic send_request(request_t r);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {{(IN_W - $bits(request_t)){1'b0}}, r};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    shadow.note_request(r);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (shadow.pending_answers.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_answer(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
    m_axis_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL owner_record_table");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    request_t r;
    walk_t mode;
    int full_tries;
    int counted;
    mode = MODE_FILL;
    full_tries = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(make_request(OP_LOOKUP, 32'h0000_0000, 32'h1111_1111, 32'h2222_2222));
    send_request(make_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_request(make_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_request(make_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
    send_request(make_request(OP_INSERT, 32'h1234_5678, 32'hC3C3_C3C3, 32'h3C3C_3C3C));
    hold_until_drained();
    send_request(make_request(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'h0000_0000, 32'h0, 32'h0));
    send_request(make_request(OP_REMOVE, 32'h1234_5678, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0));
    send_request(make_request(OP_REMOVE, 32'h1234_5678, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0));
    send_request(make_request(OP_REMOVE, 32'h0000_0000, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_request(make_request(OP_UNUSED, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_request(make_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_request(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0));

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 12 : (ph == 1) ? 49 : 0;
      dst_idle = (ph == 0) ? 49 : (ph == 1) ? 12 : 0;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        if (mode == MODE_FILL && shadow.used == TABLE_DEPTH) begin
          full_tries++;
          if (full_tries > 4) mode = MODE_DRAIN;
        end else if (mode == MODE_DRAIN && shadow.used <= 2) begin
          mode = MODE_MIXED;
        end
        r = pick_request(mode);
        send_request(r);
        if (r.op != OP_UNUSED) counted++;
        if ($urandom_range(49) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.failures == 0 && shadow.pending_answers.size() == 0)
      $display("PASS owner_record_table");
    else
      $display("FAIL owner_record_table");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ort_pkg.sv
rtl/core/ort_store.sv
rtl/core/owner_record_table.sv
rtl/core/ort_checker.sv
sim/tb_owner_record_table.sv
